>>> src/stpu_pkg.sv
// Shared constants, types and elaboration-time helpers for the short-term plasticity block.
package stpu_pkg;

  localparam int FRAC_BITS = 15;
  localparam logic [15:0] ONE = 16'(1 << FRAC_BITS);
  localparam logic [15:0] HALF = 16'(1 << (FRAC_BITS - 1));

  localparam int EXP_TABLE_DEPTH_DEF = 256;
  localparam int EXP_TABLE_DEPTH_MIN = 32;
  localparam int EXP_TABLE_DEPTH_MAX = 4096;

  // divider: quotient bits resolved per pipeline stage
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int EXP_LAT = 2;
  localparam int MAC_LAT = 6;

  localparam logic [15:0] SCALE_RESET = 16'd256;
  localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;

  // operands of the arithmetic chain, carried alongside the divider
  typedef struct packed {
    logic [15:0]        base_use;
    logic [15:0]        use_prev;
    logic [15:0]        resources_prev;
    logic signed [15:0] weight;
  } operand_t;

  function automatic logic [15:0] sat_frac(input logic [15:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  // exp(-s) in Q32 by Taylor series, s in Q32
  function automatic logic [63:0] exp_ratio(input logic [63:0] s);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = Q32_ONE;
    pos  = Q32_ONE;
    neg  = '0;
    for (int n = 1; n < 24; n++) begin
      term = (term * s) >> 32;
      term = term / 64'(n);
      if ((n % 2) == 1) neg = neg + term;
      else pos = pos + term;
    end
    return pos - neg;
  endfunction

endpackage

>>> src/stpu_if.sv
// Valid/ready channels for spike items in and plasticity results out.
interface stpu_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        base_use;
  logic [15:0]        depression_tau;
  logic [15:0]        facilitation_tau;
  logic [15:0]        use_prev;
  logic [15:0]        resources_prev;
  logic [15:0]        time_since_last;
  logic signed [15:0] weight;

  modport source (output valid, base_use, depression_tau, facilitation_tau, use_prev,
                  resources_prev, time_since_last, weight, input ready);
  modport sink (input valid, base_use, depression_tau, facilitation_tau, use_prev,
                resources_prev, time_since_last, weight, output ready);
endinterface

interface stpu_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        use_new;
  logic [15:0]        resources_new;
  logic signed [31:0] current;

  modport source (output valid, use_new, resources_new, current, input ready);
  modport sink (input valid, use_new, resources_new, current, output ready);
endinterface

>>> src/short_term_plasticity_update.sv
// Short-term plasticity update (u', R', current) per synaptic spike item, fully pipelined.
// Throughput: one item per cycle when not stalled; every stage, divider included, can take a new item each cycle.
// Stalls: each stage holds when full and the next one cannot take; bubbles fill up.
// Reset (rst, synchronous): all stage valid bits clear, output_scale returns to 1.0 (256).
module short_term_plasticity_update #(
  parameter int EXP_TABLE_DEPTH = stpu_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  stpu_in_if.sink     spike,
  stpu_out_if.source  result
);

  localparam int QB = $clog2(EXP_TABLE_DEPTH) + 16;
  localparam int NDS = (QB + stpu_pkg::DIV_BITS_PER_STAGE - 1) / stpu_pkg::DIV_BITS_PER_STAGE;
  localparam int DIV_LAT = NDS + 1;
  localparam int PRE_LAT = DIV_LAT + stpu_pkg::EXP_LAT;
  localparam int NS = PRE_LAT + stpu_pkg::MAC_LAT;

  // output_scale, Q8.8; the user must write it only while idle, which the block does not enforce
  logic [15:0] scale;

  always_ff @(posedge clk) begin
    if (rst) scale <= stpu_pkg::SCALE_RESET;
    else if (wr_en) scale <= wr_data;
  end

  // Stage occupancy. A stage loads when it is empty or its successor loads,
  // so earlier items keep moving up into empty stages while a later stage holds.
  logic [NS-1:0] vld;
  logic [NS:0]   adv;

  always_comb begin
    adv[NS] = result.ready;
    for (int k = NS - 1; k >= 0; k--) adv[k] = !vld[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= spike.valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign spike.ready  = adv[0];
  assign result.valid = vld[NS-1];

  // operands ride along while both exponentials are formed
  stpu_pkg::operand_t opnd [PRE_LAT];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      opnd[0].base_use       <= stpu_pkg::sat_frac(spike.base_use);
      opnd[0].use_prev       <= stpu_pkg::sat_frac(spike.use_prev);
      opnd[0].resources_prev <= stpu_pkg::sat_frac(spike.resources_prev);
      opnd[0].weight         <= spike.weight;
    end
    for (int k = 1; k < PRE_LAT; k++) begin
      if (adv[k]) opnd[k] <= opnd[k-1];
    end
  end

  // ratio dt/tau as table index and 16-bit fraction, one divider per time constant
  logic [QB-1:0] quot_f, quot_d;
  logic          zero_f, zero_d;

  stpu_div #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_div_f (
    .clk  (clk),
    .en   (adv[DIV_LAT-1:0]),
    .dt   (spike.time_since_last),
    .tau  (spike.facilitation_tau),
    .quot (quot_f),
    .zero (zero_f)
  );

  stpu_div #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_div_d (
    .clk  (clk),
    .en   (adv[DIV_LAT-1:0]),
    .dt   (spike.time_since_last),
    .tau  (spike.depression_tau),
    .quot (quot_d),
    .zero (zero_d)
  );

  // exp(-dt/F) and exp(-dt/D) in Q1.15
  logic [15:0] decay_f, decay_d;

  stpu_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_f (
    .clk   (clk),
    .en    (adv[PRE_LAT-1:DIV_LAT]),
    .quot  (quot_f),
    .zero  (zero_f),
    .decay (decay_f)
  );

  stpu_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_d (
    .clk   (clk),
    .en    (adv[PRE_LAT-1:DIV_LAT]),
    .quot  (quot_d),
    .zero  (zero_d),
    .decay (decay_d)
  );

  // u', R' and current; its last stage is the output register
  stpu_mac u_mac (
    .clk           (clk),
    .en            (adv[NS-1:PRE_LAT]),
    .opnd          (opnd[PRE_LAT-1]),
    .decay_f       (decay_f),
    .decay_d       (decay_d),
    .scale         (scale),
    .use_new       (result.use_new),
    .resources_new (result.resources_new),
    .current       (result.current)
  );

endmodule

>>> src/stpu_div.sv
// Pipelined restoring divider forming the exp table position dt*DEPTH*2^12/tau.
module stpu_div #(
  parameter int EXP_TABLE_DEPTH = stpu_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                                          clk,
  input  logic [((($clog2(EXP_TABLE_DEPTH) + 16) + stpu_pkg::DIV_BITS_PER_STAGE - 1)
                / stpu_pkg::DIV_BITS_PER_STAGE):0]       en,
  input  logic [15:0]                                   dt,
  input  logic [15:0]                                   tau,
  output logic [$clog2(EXP_TABLE_DEPTH) + 15:0]         quot,
  output logic                                          zero
);

  localparam int QB = $clog2(EXP_TABLE_DEPTH) + 16;
  localparam int BPS = stpu_pkg::DIV_BITS_PER_STAGE;
  localparam int NDS = (QB + BPS - 1) / BPS;
  localparam int NW = QB + 12;
  localparam int SCALE = EXP_TABLE_DEPTH * 4096;

  logic [15:0]   rem   [NDS+1];
  logic [QB-1:0] low   [NDS+1];
  logic [QB-1:0] q     [NDS+1];
  logic [15:0]   tau_r [NDS+1];
  logic          zero_r[NDS+1];

  logic [NW-1:0] dividend;
  assign dividend = NW'(dt) * NW'(SCALE);

  // stage 0: dividend split, decay-to-zero detect (tau zero or ratio of 16 or more)
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]    <= 16'(dividend[NW-1:QB]);
      low[0]    <= dividend[QB-1:0];
      q[0]      <= '0;
      tau_r[0]  <= tau;
      zero_r[0] <= (tau == 16'd0) || ({4'b0, dt} >= {tau, 4'b0});
    end
  end

  for (genvar s = 1; s <= NDS; s++) begin : g_stage
    logic [15:0]   rem_next;
    logic [QB-1:0] low_next;
    logic [QB-1:0] q_next;

    always_comb begin : step
      logic [16:0] trial;
      rem_next = rem[s-1];
      low_next = low[s-1];
      q_next   = q[s-1];
      for (int b = 0; b < BPS; b++) begin
        if (((s - 1) * BPS + b) < QB) begin
          trial    = {rem_next, low_next[QB-1]};
          low_next = low_next << 1;
          if (trial >= {1'b0, tau_r[s-1]}) begin
            rem_next = 16'(trial - {1'b0, tau_r[s-1]});
            q_next   = {q_next[QB-2:0], 1'b1};
          end else begin
            rem_next = trial[15:0];
            q_next   = {q_next[QB-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem[s]    <= rem_next;
        low[s]    <= low_next;
        q[s]      <= q_next;
        tau_r[s]  <= tau_r[s-1];
        zero_r[s] <= zero_r[s-1];
      end
    end
  end

  assign quot = q[NDS];
  assign zero = zero_r[NDS];

endmodule

>>> src/stpu_exp.sv
// Table lookup with linear interpolation of exp(-ratio), two stages, Q1.15 result.
module stpu_exp #(
  parameter int EXP_TABLE_DEPTH = stpu_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic [1:0]                            en,
  input  logic [$clog2(EXP_TABLE_DEPTH) + 15:0] quot,
  input  logic                                  zero,
  output logic [15:0]                           decay
);

  localparam int IW = $clog2(EXP_TABLE_DEPTH);
  localparam logic [63:0] STEP = (64'd16 << 32) / EXP_TABLE_DEPTH;
  localparam logic [63:0] RATIO = stpu_pkg::exp_ratio(STEP);
  localparam logic [33:0] RND = 34'(1) << (31 - stpu_pkg::FRAC_BITS);

  typedef logic [32:0] rom_t [EXP_TABLE_DEPTH];

  // entry k is exp(-16k/DEPTH) in Q32; the upper table holds entry k+1
  function automatic rom_t build_rom(input logic [63:0] r, input bit upper);
    rom_t        t;
    logic [63:0] v;
    v = stpu_pkg::Q32_ONE;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      if (!upper && k < EXP_TABLE_DEPTH) t[k] = 33'(v);
      if (upper && k > 0) t[k-1] = 33'(v);
      v = (v * r + 64'h8000_0000) >> 32;
    end
    return t;
  endfunction

  localparam rom_t ROM_LO = build_rom(RATIO, 1'b0);
  localparam rom_t ROM_HI = build_rom(RATIO, 1'b1);

  logic [IW-1:0] idx;
  assign idx = quot[IW+15:16];

  logic [32:0] base;
  logic [32:0] diff;
  logic [15:0] frac;
  logic        zero_a;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      base   <= ROM_LO[idx];
      diff   <= ROM_LO[idx] - ROM_HI[idx];
      frac   <= quot[15:0];
      zero_a <= zero;
    end
  end

  logic [48:0] prod;
  logic [32:0] interp;
  logic [33:0] rounded;
  logic [15:0] decay_next;

  always_comb begin
    prod    = {16'b0, diff} * {33'b0, frac};
    interp  = base - prod[48:16];
    rounded = {1'b0, interp} + RND;
    if (zero_a) decay_next = '0;
    else if (rounded[33:32-stpu_pkg::FRAC_BITS] > 17'(stpu_pkg::ONE)) decay_next = stpu_pkg::ONE;
    else decay_next = rounded[32-stpu_pkg::FRAC_BITS+15:32-stpu_pkg::FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en[1]) decay <= decay_next;
  end

endmodule

>>> src/stpu_mac.sv
// Six-stage multiply chain: u', R' and the scaled, saturated synaptic current.
module stpu_mac (
  input  logic                  clk,
  input  logic [5:0]            en,
  input  stpu_pkg::operand_t    opnd,
  input  logic [15:0]           decay_f,
  input  logic [15:0]           decay_d,
  input  logic [15:0]           scale,
  output logic [15:0]           use_new,
  output logic [15:0]           resources_new,
  output logic signed [31:0]    current
);

  localparam int FB = stpu_pkg::FRAC_BITS;

  // stage 0: u*(1-U), scale*|w|
  logic [15:0] m1, u0, r0, ef0, ed0;
  logic [31:0] sw0;
  logic        neg0;
  logic [31:0] p0;
  logic [15:0] wmag;

  always_comb begin
    p0   = 32'(opnd.use_prev) * 32'(stpu_pkg::ONE - opnd.base_use) + 32'(stpu_pkg::HALF);
    wmag = opnd.weight[15] ? 16'(-opnd.weight) : opnd.weight;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m1   <= p0[FB+15:FB];
      u0   <= opnd.base_use;
      r0   <= opnd.resources_prev;
      ef0  <= decay_f;
      ed0  <= decay_d;
      sw0  <= 32'(scale) * 32'(wmag);
      neg0 <= opnd.weight[15];
    end
  end

  // stage 1: u' = U + m1*eF, clamped
  logic [15:0] un1, r1, ed1;
  logic [31:0] sw1;
  logic        neg1;
  logic [31:0] p1;
  logic [16:0] s1;

  always_comb begin
    p1 = 32'(m1) * 32'(ef0) + 32'(stpu_pkg::HALF);
    s1 = {1'b0, u0} + {1'b0, p1[FB+15:FB]};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      un1  <= (s1 > 17'(stpu_pkg::ONE)) ? stpu_pkg::ONE : s1[15:0];
      r1   <= r0;
      ed1  <= ed0;
      sw1  <= sw0;
      neg1 <= neg0;
    end
  end

  // stage 2: c = 1 - R + u'*R
  logic [16:0] c2;
  logic [15:0] un2, ed2;
  logic [31:0] sw2;
  logic        neg2;
  logic [31:0] p2;

  assign p2 = 32'(un1) * 32'(r1) + 32'(stpu_pkg::HALF);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c2   <= 17'(stpu_pkg::ONE) - 17'(r1) + 17'(p2[FB+15:FB]);
      un2  <= un1;
      ed2  <= ed1;
      sw2  <= sw1;
      neg2 <= neg1;
    end
  end

  // stage 3: R' = 1 - c*eD, floored at zero
  logic [15:0] rn3, un3;
  logic [31:0] sw3;
  logic        neg3;
  logic [33:0] p3;
  logic [18:0] d3;

  always_comb begin
    p3 = 34'(c2) * 34'(ed2) + 34'(stpu_pkg::HALF);
    d3 = p3[FB+18:FB];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rn3  <= (d3 >= 19'(stpu_pkg::ONE)) ? 16'd0 : 16'(19'(stpu_pkg::ONE) - d3);
      un3  <= un2;
      sw3  <= sw2;
      neg3 <= neg2;
    end
  end

  // stage 4: u'*R'
  logic [15:0] m4, un4, rn4;
  logic [31:0] sw4;
  logic        neg4;
  logic [31:0] p4;

  assign p4 = 32'(un3) * 32'(rn3) + 32'(stpu_pkg::HALF);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      m4   <= p4[FB+15:FB];
      un4  <= un3;
      rn4  <= rn3;
      sw4  <= sw3;
      neg4 <= neg3;
    end
  end

  // stage 5: magnitude, sign and saturation of the current
  logic [47:0] p5;
  logic [32:0] mag;
  logic [32:0] mag_neg;
  logic [31:0] cur_next;

  always_comb begin
    p5      = {16'b0, sw4} * {32'b0, m4} + 48'(stpu_pkg::HALF);
    mag     = p5[FB+32:FB];
    mag_neg = 33'd0 - mag;
    if (neg4) cur_next = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : mag_neg[31:0];
    else cur_next = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      use_new       <= un4;
      resources_new <= rn4;
      current       <= cur_next;
    end
  end

endmodule

>>> bench/short_term_plasticity_update_test.sv
// Testbench for the short-term plasticity update block: directed table, random items, checking.
`timescale 1ns / 1ps

module short_term_plasticity_update_test;

  localparam int          DEPTH      = 256;
  localparam int          LIMIT      = 400000;
  localparam int          DRAIN      = 40;
  localparam int          PHASE_LEN  = 150;
  localparam int          N_PHASES   = 6;
  localparam int          N_DIRECTED = 20;
  localparam logic [63:0] ONE64      = 64'd1 << stpu_pkg::FRAC_BITS;
  localparam logic [63:0] HALF64     = 64'd1 << (stpu_pkg::FRAC_BITS - 1);

  // One spike item as seen on the input channel.
  typedef struct packed {
    logic [15:0]        base_use;
    logic [15:0]        depression_tau;
    logic [15:0]        facilitation_tau;
    logic [15:0]        use_prev;
    logic [15:0]        resources_prev;
    logic [15:0]        time_since_last;
    logic signed [15:0] weight;
  } spike_t;

  // One plasticity result: u', R' and the synaptic current.
  typedef struct packed {
    logic [15:0]        use_new;
    logic [15:0]        resources_new;
    logic signed [31:0] current;
  } plast_t;

  // Directed row: the item, and a typed-in result where it is obvious.
  typedef struct packed {
    spike_t spk;
    logic   known;
    plast_t res;
  } dir_row_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic [15:0] wr_data;

  stpu_in_if  spike_ch ();
  stpu_out_if result_ch ();

  short_term_plasticity_update dut (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_data(wr_data),
    .spike  (spike_ch),
    .result (result_ch)
  );

  // Predictor state: the decay table and its own copy of the scale register.
  logic [63:0] decay_rom [DEPTH + 1];
  logic [15:0] scale_reg;

  plast_t pending_q [$];
  int     errors;
  int     checked;
  int     cycles;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_off;          // long receiver hold-off, counted down by the receiver

  // exp(-16/DEPTH) by series, then powers of it with rounding, all in Q32.
  function automatic void fill_decay_rom();
    logic [63:0] step;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] ratio;
    step = (64'd16 << 32) / 64'(DEPTH);
    term = 64'd1 << 32;
    pos  = 64'd1 << 32;
    neg  = '0;
    for (int n = 1; n < 24; n++) begin
      term = (term * step) >> 32;
      term = term / 64'(n);
      if (n & 1) neg = neg + term;
      else pos = pos + term;
    end
    ratio = pos - neg;
    decay_rom[0] = 64'd1 << 32;
    for (int k = 1; k <= DEPTH; k++)
      decay_rom[k] = (decay_rom[k - 1] * ratio + (64'd1 << 31)) >> 32;
  endfunction

  // exp(-dt/tau) in Q1.15; zero for tau 0 or a ratio of 16 or more.
  function automatic logic [63:0] decay_factor(logic [15:0] dt, logic [15:0] tau);
    logic [63:0] pos;
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] e;
    if (tau == 0) return 64'd0;
    pos = ((64'(dt) << 16) * 64'(DEPTH)) / (64'd16 * 64'(tau));
    idx = pos >> 16;
    if (idx >= 64'(DEPTH)) return 64'd0;
    frac = pos & 64'hFFFF;
    e = decay_rom[idx] - (((decay_rom[idx] - decay_rom[idx + 1]) * frac) >> 16);
    e = (e + (64'd1 << (31 - stpu_pkg::FRAC_BITS))) >> (32 - stpu_pkg::FRAC_BITS);
    return (e > ONE64) ? ONE64 : e;
  endfunction

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a * b + HALF64) >> stpu_pkg::FRAC_BITS;
  endfunction

  function automatic logic [63:0] clamp_frac(logic [15:0] v);
    return (64'(v) > ONE64) ? ONE64 : 64'(v);
  endfunction

  function automatic plast_t predict_plasticity(spike_t s);
    logic [63:0] u_base;
    logic [63:0] u_old;
    logic [63:0] r_old;
    logic [63:0] e_fac;
    logic [63:0] e_dep;
    logic [63:0] u_nxt;
    logic [63:0] r_nxt;
    logic [63:0] deficit;
    logic [63:0] prod;
    logic [63:0] mag;
    logic [63:0] wmag;
    int          w;
    plast_t      p;
    u_base = clamp_frac(s.base_use);
    u_old  = clamp_frac(s.use_prev);
    r_old  = clamp_frac(s.resources_prev);
    e_fac  = decay_factor(s.time_since_last, s.facilitation_tau);
    e_dep  = decay_factor(s.time_since_last, s.depression_tau);
    // facilitation: u' = U + u(1-U)eF
    u_nxt = u_base + qmul(qmul(u_old, ONE64 - u_base), e_fac);
    if (u_nxt > ONE64) u_nxt = ONE64;
    // depression: R' = 1 - (1 - R + u'R)eD, floored at zero
    deficit = qmul(ONE64 - r_old + qmul(u_nxt, r_old), e_dep);
    r_nxt = (deficit >= ONE64) ? 64'd0 : ONE64 - deficit;
    prod = qmul(u_nxt, r_nxt);
    w = s.weight;
    wmag = 64'((w < 0) ? -w : w);
    mag = (64'(scale_reg) * wmag * prod + HALF64) >> stpu_pkg::FRAC_BITS;
    p.use_new       = u_nxt[15:0];
    p.resources_new = r_nxt[15:0];
    if (w < 0) p.current = (mag > 64'h8000_0000) ? 32'sh8000_0000 : -mag[31:0];
    else p.current = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
    return p;
  endfunction

  // Directed table: extremes, instant decay, fractions above one, ratio edges.
  dir_row_t directed_rows [N_DIRECTED] = '{
    // long gap: no memory, u' = U, R' = 1
    '{'{16'd32768, 16'd1, 16'd1, 16'd0, 16'd0, 16'd65535, 16'sd256}, 1'b1,
      '{16'd32768, 16'd32768, 32'sd65536}},
    '{'{16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd65535, 16'sd256}, 1'b1,
      '{16'd0, 16'd32768, 32'sd0}},
    '{'{16'd32768, 16'd1, 16'd1, 16'd32768, 16'd32768, 16'd65535, -16'sd32768}, 1'b1,
      '{16'd32768, 16'd32768, -32'sd8388608}},
    '{'{16'd32768, 16'd1, 16'd1, 16'd0, 16'd0, 16'd65535, 16'sd32767}, 1'b1,
      '{16'd32768, 16'd32768, 32'sd8388352}},
    // zero time constants decay instantly, even at dt 0
    '{'{16'd16384, 16'd0, 16'd0, 16'd32768, 16'd32768, 16'd0, 16'sd256}, 1'b1,
      '{16'd16384, 16'd32768, 32'sd32768}},
    // fractions above one saturate to one
    '{'{16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'd65535, 16'sd256}, 1'b1,
      '{16'd32768, 16'd32768, 32'sd65536}},
    '{'{16'd8192, 16'd100, 16'd100, 16'd32768, 16'd32768, 16'd0, 16'sd256}, 1'b0, '0},
    '{'{16'd8192, 16'd65535, 16'd65535, 16'd20000, 16'd30000, 16'd0, -16'sd1}, 1'b0, '0},
    '{'{16'd1000, 16'd65535, 16'd65535, 16'd32768, 16'd100, 16'd65535, 16'sd1}, 1'b0, '0},
    '{'{16'd4000, 16'd100, 16'd100, 16'd16000, 16'd16000, 16'd1599, 16'sd512}, 1'b0, '0},
    '{'{16'd4000, 16'd100, 16'd100, 16'd16000, 16'd16000, 16'd1600, 16'sd512}, 1'b0, '0},
    '{'{16'd5000, 16'd1, 16'd1, 16'd30000, 16'd1000, 16'd1, -16'sd700}, 1'b0, '0},
    '{'{16'd0, 16'd50, 16'd20, 16'd0, 16'd0, 16'd0, 16'sd32767}, 1'b0, '0},
    '{'{16'd32768, 16'd300, 16'd700, 16'd32768, 16'd0, 16'd150, -16'sd32768}, 1'b0, '0},
    '{'{16'd12000, 16'd0, 16'd400, 16'd9000, 16'd25000, 16'd37, 16'sd300}, 1'b0, '0},
    '{'{16'd12000, 16'd400, 16'd0, 16'd9000, 16'd25000, 16'd37, 16'sd300}, 1'b0, '0},
    '{'{16'd32769, 16'd255, 16'd257, 16'd32769, 16'd32769, 16'd255, 16'sh7F00}, 1'b0, '0},
    '{'{16'h5555, 16'hAAAA, 16'h5555, 16'h2AAA, 16'h5555, 16'hAAAA, 16'sh5555}, 1'b0, '0},
    '{'{16'h2AAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h2AAA, 16'h5555, -16'sh5556}, 1'b0, '0},
    '{'{16'd20000, 16'd3, 16'd2, 16'd20000, 16'd20000, 16'd2, -16'sd256}, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit: a hang anywhere ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, pending_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: check accepted items, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result u=%0d R=%0d cur=%0d", $time,
                 result_ch.use_new, result_ch.resources_new, result_ch.current);
      end else begin
        plast_t want;
        want = pending_q.pop_front();
        checked++;
        if (result_ch.use_new !== want.use_new) begin
          errors++;
          $display("%0t: use_new expected %0d got %0d", $time,
                   want.use_new, result_ch.use_new);
        end
        if (result_ch.resources_new !== want.resources_new) begin
          errors++;
          $display("%0t: resources_new expected %0d got %0d", $time,
                   want.resources_new, result_ch.resources_new);
        end
        if (result_ch.current !== want.current) begin
          errors++;
          $display("%0t: current expected %0d got %0d", $time,
                   want.current, result_ch.current);
        end
      end
    end
    if (hold_off > 0) begin
      hold_off--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one item, with random idle cycles first; valid stays up between items unless idle cycles are drawn.
  task automatic offer_spike(spike_t s, logic known, plast_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      spike_ch.valid <= 1'b0;
      @(posedge clk);
    end
    spike_ch.valid            <= 1'b1;
    spike_ch.base_use         <= s.base_use;
    spike_ch.depression_tau   <= s.depression_tau;
    spike_ch.facilitation_tau <= s.facilitation_tau;
    spike_ch.use_prev         <= s.use_prev;
    spike_ch.resources_prev   <= s.resources_prev;
    spike_ch.time_since_last  <= s.time_since_last;
    spike_ch.weight           <= s.weight;
    @(posedge clk);
    while (!spike_ch.ready) @(posedge clk);
    pending_q.insert(pending_q.size(), known ? typed : predict_plasticity(s));
  endtask

  // Drain, let the pipeline settle, then write the scale register.
  task automatic set_scale(logic [15:0] v);
    spike_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    wr_en   <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en     <= 1'b0;
    scale_reg = v;
  endtask

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(9))
      0:       return 16'($urandom);            // often above one
      1:       return ($urandom_range(1)) ? 16'd32768 : 16'd0;
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic logic [15:0] rand_tau();
    case ($urandom_range(9))
      0:       return 16'd0;
      1, 2:    return 16'($urandom);
      default: return 16'($urandom_range(400, 1));
    endcase
  endfunction

  // Mostly gaps comparable to the time constants, so the decay table is used.
  function automatic spike_t rand_spike();
    spike_t s;
    s.base_use         = rand_frac();
    s.depression_tau   = rand_tau();
    s.facilitation_tau = rand_tau();
    s.use_prev         = rand_frac();
    s.resources_prev   = rand_frac();
    s.time_since_last  = ($urandom_range(3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(2000));
    s.weight           = 16'($urandom);
    return s;
  endfunction

  initial begin
    logic [15:0] phase_scale [N_PHASES];
    int          idle_mode   [N_PHASES];
    int          total;
    errors          = 0;
    checked         = 0;
    cycles          = 0;
    hold_off        = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    scale_reg       = stpu_pkg::SCALE_RESET;
    rst             = 1'b1;
    wr_en           = 1'b0;
    wr_data         = '0;
    spike_ch.valid  = 1'b0;
    spike_ch.base_use = '0;
    spike_ch.depression_tau = '0;
    spike_ch.facilitation_tau = '0;
    spike_ch.use_prev = '0;
    spike_ch.resources_prev = '0;
    spike_ch.time_since_last = '0;
    spike_ch.weight = '0;
    result_ch.ready = 1'b0;
    fill_decay_rom();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at the reset scale of 1.0.
    foreach (directed_rows[i])
      offer_spike(directed_rows[i].spk, directed_rows[i].known, directed_rows[i].res);
    total = N_DIRECTED;

    // Random phases: scale extremes and random values, each idling pattern.
    phase_scale = '{16'd0, 16'hFFFF, 16'($urandom), 16'd1, 16'($urandom),
                    stpu_pkg::SCALE_RESET};
    idle_mode   = '{0, 1, 2, 3, 2, 0};
    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_scale(phase_scale[ph]);
      case (idle_mode[ph])
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      // Long output hold-off while the sender keeps pushing: fills the pipeline.
      if (ph == 0) hold_off = 300;
      for (int n = 0; n < PHASE_LEN; n++)
        offer_spike(rand_spike(), 1'b0, '0);
      total += PHASE_LEN;
    end

    spike_ch.valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d spike items (%0d directed), checked %0d results over %0d scale settings",
             total, N_DIRECTED, checked, N_PHASES + 1);
    $display("with idle/stall patterns and a long output hold-off; %0d field errors", errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
